// ===== src/ocmf_pkg.sv =====
// ----------------------------------------------------------------------------
// ocmf_pkg
// Shared types, constants and window helpers for the obstacle closing filter.
// ----------------------------------------------------------------------------
package ocmf_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_KERNEL = 15;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int ROW_W      = 17;
	localparam int LD_W       = 15;
	localparam int PIX_AW     = 14;
	localparam int PIX_DEPTH  = 1 << PIX_AW;
	localparam int FIFO_DEPTH = 16;
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH) + 1;
	localparam int PIPE_DEPTH = 7;

	localparam logic [7:0] PIX_FREE = 8'd255;
	localparam logic [7:0] PIX_OBST = 8'd0;

	typedef enum logic [1:0] {
		CFG_KERNEL = 2'd0,
		CFG_WIDTH  = 2'd1,
		CFG_HEIGHT = 2'd2
	} cfg_idx_t;

	// effective geometry, already clamped
	typedef struct packed {
		logic [3:0]      k;
		logic [2:0]      hi;
		logic [10:0]     w;
		logic [15:0]     h;
		logic [LD_W-1:0] ld;
		logic [LD_W-1:0] two_ld;
	} cfg_t;

	// one pipeline position
	typedef struct packed {
		logic             valid;
		logic             bit_in;
		logic [ROW_W-1:0] in_row;
		logic [COL_W-1:0] in_col;
		logic             dil_act;
		logic [ROW_W-1:0] dil_row;
		logic [COL_W-1:0] dil_col;
		logic             emit;
		logic [COL_W-1:0] out_col;
		logic             last;
	} ev_t;

	// input of one dilate/erode unit
	typedef struct packed {
		logic             valid;
		logic             bit_in;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic [COL_W-1:0] ccol;
	} mu_in_t;

	// rows of a column word that lie inside the window and the image
	function automatic logic [MAX_KERNEL-1:0] vert_valid(input logic [ROW_W-1:0] r,
			input logic [3:0] k, input logic [15:0] h);
		logic [MAX_KERNEL-1:0] v;
		logic [ROW_W:0]        hb;
		for (int b = 0; b < MAX_KERNEL; b++) begin
			hb   = {2'b00, h} + (ROW_W+1)'(b);
			v[b] = (4'(b) < k) && (ROW_W'(b) <= r) && ({1'b0, r} < hb);
		end
		return v;
	endfunction

	// window columns that lie inside the image round centre column cc
	function automatic logic [MAX_KERNEL-1:0] horiz_valid(input logic [COL_W-1:0] cc,
			input logic [2:0] hi, input logic [3:0] k, input logic [10:0] w);
		logic [MAX_KERNEL-1:0] v;
		logic [11:0]           s;
		s = {2'b00, cc} + 12'(hi);
		for (int a = 0; a < MAX_KERNEL; a++) begin
			v[a] = (4'(a) < k) && (s >= 12'(a)) && (s < ({1'b0, w} + 12'(a)));
		end
		return v;
	endfunction

endpackage

// ===== src/ocmf_morph.sv =====
// ----------------------------------------------------------------------------
// ocmf_morph
// One dilate or erode pass: column word store with read-modify-write,
// vertical reduce, then horizontal window reduce.
// ----------------------------------------------------------------------------
module ocmf_morph import ocmf_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   erode,
	input  cfg_t   cfg,
	input  mu_in_t mu_in,
	output logic   res_valid,
	output logic   res
);

	logic [MAX_KERNEL-1:0] col_mem [MAX_WIDTH];

	logic                  valid_s1, valid_s2, valid_s3;
	logic                  bit_s1;
	logic [ROW_W-1:0]      row_s1;
	logic [COL_W-1:0]      col_s1, ccol_s1, ccol_s2;
	logic [MAX_KERNEL-1:0] rd_s1, fwd_word_s1;
	logic                  fwd_s1;
	logic                  colr_s2, res_s3;
	logic [MAX_KERNEL-1:0] win_q;

	logic [MAX_KERNEL-1:0] word, wr_word, vv, win_new, hv;
	logic                  colr, hres;

	// column store: read at the new position, write back in the following cycle
	always_ff @(posedge clk) begin
		if (mu_in.valid) begin
			rd_s1 <= col_mem[mu_in.col];
		end
		if (valid_s1) begin
			col_mem[col_s1] <= wr_word;
		end
	end

	// shift the new row bit into the column word, then reduce over rows
	always_comb begin
		word    = fwd_s1 ? fwd_word_s1 : rd_s1;
		wr_word = {word[MAX_KERNEL-2:0], bit_s1};
		vv      = vert_valid(row_s1, cfg.k, cfg.h);
		colr    = erode ? (&(wr_word | ~vv)) : (|(wr_word & vv));
	end

	// horizontal window over the column results
	always_comb begin
		win_new = {win_q[MAX_KERNEL-2:0], colr_s2};
		hv      = horiz_valid(ccol_s2, cfg.hi, cfg.k, cfg.w);
		hres    = erode ? (&(win_new | ~hv)) : (|(win_new & hv));
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			fwd_s1   <= 1'b0;
			win_q    <= '0;
		end else begin
			valid_s1 <= mu_in.valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			// same column written back this cycle: take the new word
			fwd_s1   <= mu_in.valid && valid_s1 && (mu_in.col == col_s1);
			if (valid_s2) begin
				win_q <= win_new;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		bit_s1      <= mu_in.bit_in;
		row_s1      <= mu_in.row;
		col_s1      <= mu_in.col;
		ccol_s1     <= mu_in.ccol;
		fwd_word_s1 <= wr_word;
		colr_s2     <= colr;
		ccol_s2     <= ccol_s1;
		res_s3      <= hres;
	end

	assign res_valid = valid_s3;
	assign res       = res_s3;

endmodule

// ===== src/ocmf_seq.sv =====
// ----------------------------------------------------------------------------
// ocmf_seq
// Position sequencer: frame counters, flush and tail handling, pixel delay
// store. Issues one pipeline position per accepted pixel or drain step.
// ----------------------------------------------------------------------------
module ocmf_seq import ocmf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       clear,
	input  logic       room,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,
	input  logic       s_tuser,
	output ev_t        ev_s1,
	output logic [7:0] pix_s1
);

	logic [7:0] pix_mem [PIX_DEPTH];

	logic [ROW_W-1:0]  ir_q, dr_q;
	logic [COL_W-1:0]  ic_q, dc_q, oc_q;
	logic [15:0]       or_q;
	logic [LD_W-1:0]   pc_q;
	logic [PIX_AW-1:0] wp_q, op_q;

	logic [ROW_W-1:0]  c_ir, c_dr;
	logic [COL_W-1:0]  c_ic, c_dc, c_oc;
	logic [15:0]       c_or;
	logic [LD_W-1:0]   c_pc;
	logic [PIX_AW-1:0] c_wp, c_op;

	logic done, self_adv, acc, pix_ev, fl_ev, adv, restart;
	logic dil_act, emit, last;
	ev_t  ev;

	logic [7:0] rd_s1, byp_pix_s1;
	logic       byp_s1;

	// frame complete: tail may be drained, a new pixel restarts
	assign done     = ir_q >= {1'b0, cfg.h};
	assign self_adv = done && (pc_q < cfg.two_ld);
	assign s_tready = room && !self_adv;
	assign acc      = s_tvalid && s_tready;
	assign pix_ev   = acc && !s_tuser;
	assign fl_ev    = acc && s_tuser && done;
	assign adv      = room && (pix_ev || fl_ev || self_adv);
	assign restart  = pix_ev && done;

	// counters for this position
	always_comb begin
		c_ir = restart ? '0 : ir_q;
		c_ic = restart ? '0 : ic_q;
		c_dr = restart ? '0 : dr_q;
		c_dc = restart ? '0 : dc_q;
		c_or = restart ? '0 : or_q;
		c_oc = restart ? '0 : oc_q;
		c_pc = restart ? '0 : pc_q;
		c_wp = restart ? '0 : wp_q;
		c_op = restart ? '0 : op_q;
		dil_act = c_pc >= cfg.ld;
		emit    = c_pc >= cfg.two_ld;
		last    = emit && (c_or == cfg.h - 16'd1) && ({1'b0, c_oc} == cfg.w - 11'd1);
	end

	always_comb begin
		ev.valid   = adv;
		ev.bit_in  = pix_ev && (s_tdata == PIX_OBST);
		ev.in_row  = c_ir;
		ev.in_col  = c_ic;
		ev.dil_act = dil_act;
		ev.dil_row = c_dr;
		ev.dil_col = c_dc;
		ev.emit    = emit;
		ev.out_col = c_oc;
		ev.last    = last;
	end

	// counter update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ir_q <= '0; ic_q <= '0; dr_q <= '0; dc_q <= '0;
			or_q <= '0; oc_q <= '0; pc_q <= '0; wp_q <= '0; op_q <= '0;
		end else if (clear || (adv && last)) begin
			ir_q <= '0; ic_q <= '0; dr_q <= '0; dc_q <= '0;
			or_q <= '0; oc_q <= '0; pc_q <= '0; wp_q <= '0; op_q <= '0;
		end else if (adv) begin
			if (({1'b0, c_ic} + 11'd1) == cfg.w) begin
				ic_q <= '0;
				ir_q <= c_ir + 1'b1;
			end else begin
				ic_q <= c_ic + 1'b1;
				ir_q <= c_ir;
			end
			pc_q <= (c_pc < cfg.two_ld) ? c_pc + 1'b1 : c_pc;
			wp_q <= c_wp + 1'b1;
			if (dil_act) begin
				if (({1'b0, c_dc} + 11'd1) == cfg.w) begin
					dc_q <= '0;
					dr_q <= c_dr + 1'b1;
				end else begin
					dc_q <= c_dc + 1'b1;
					dr_q <= c_dr;
				end
			end else begin
				dc_q <= c_dc;
				dr_q <= c_dr;
			end
			if (emit) begin
				op_q <= c_op + 1'b1;
				if (({1'b0, c_oc} + 11'd1) == cfg.w) begin
					oc_q <= '0;
					or_q <= c_or + 1'b1;
				end else begin
					oc_q <= c_oc + 1'b1;
					or_q <= c_or;
				end
			end else begin
				op_q <= c_op;
				oc_q <= c_oc;
				or_q <= c_or;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ev_s1 <= '0;
		end else begin
			ev_s1 <= ev;
		end
	end

	// pixel delay store; bypass when the output position is the one written
	always_ff @(posedge clk) begin
		if (pix_ev) begin
			pix_mem[c_wp] <= s_tdata;
		end
		if (adv) begin
			rd_s1 <= pix_mem[c_op];
		end
		byp_s1     <= pix_ev && (c_wp == c_op);
		byp_pix_s1 <= s_tdata;
	end

	assign pix_s1 = byp_s1 ? byp_pix_s1 : rd_s1;

endmodule

// ===== src/ocmf_out_fifo.sv =====
// ----------------------------------------------------------------------------
// ocmf_out_fifo
// Result queue in front of the output channel. Keeps room for every item
// still in the pipeline, so the pipeline itself never stalls.
// ----------------------------------------------------------------------------
module ocmf_out_fifo import ocmf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic [7:0]         push_pix,
	input  logic               push_last,
	output logic               room,
	output logic [FIFO_CW-1:0] level,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [7:0]         m_tdata,
	output logic               m_tlast
);

	localparam int AW = $clog2(FIFO_DEPTH);

	logic [8:0]         buf_q [FIFO_DEPTH];
	logic [AW-1:0]      wr_q, rd_q;
	logic [FIFO_CW-1:0] cnt_q;
	logic               pop;

	assign pop      = m_tvalid && m_tready;
	assign m_tvalid = cnt_q != '0;
	assign m_tdata  = buf_q[rd_q][7:0];
	assign m_tlast  = buf_q[rd_q][8];
	assign level    = cnt_q;
	// a new item may enter only if all in-flight items still fit
	assign room     = cnt_q <= FIFO_CW'(FIFO_DEPTH - PIPE_DEPTH - 1);

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_q] <= {push_last, push_pix};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== src/obstacle_closing_map_filter_top.sv =====
// Throughput: one item per cycle while the output queue has room and the sequencer is
// not stepping itself; a flush item after the frame yields one result. For frames
// shorter than 2*L (L = B*W + B, B = K-1-K/2) the sequencer steps itself after the
// last pixel until 2*L positions are issued, before taking a flush item. The result
// of raster position i comes with the item at position i+2L (dilate, erode, queue).
// Reset: asynchronous, clears counters and config to K=3, W=1024, H=1024.
// ----------------------------------------------------------------------------
// obstacle_closing_map_filter_top
// Morphological closing of the obstacle mask of a raster map, applied back
// to the pixels: obstacle pixels fill gaps that are not marked free.
// ----------------------------------------------------------------------------
module obstacle_closing_map_filter_top import ocmf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] pixel_in
	input  logic        s_tuser,   // [0] flush
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] pixel_out
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	typedef struct packed {
		logic             valid;
		logic             dil_act;
		logic [ROW_W-1:0] dil_row;
		logic [COL_W-1:0] dil_col;
		logic [COL_W-1:0] out_col;
		logic             emit;
		logic             last;
		logic [7:0]       pix;
	} side_t;

	typedef struct packed {
		logic       emit;
		logic       last;
		logic [7:0] pix;
	} tail_t;

	logic [3:0]  kernel_q;
	logic [10:0] width_q;
	logic [15:0] height_q;
	logic        cfg_clear;
	cfg_t        cfg;
	logic [3:0]  keff;
	logic [3:0]  hi4;

	ev_t         ev_s1;
	logic [7:0]  pix_s1;
	side_t       side_s2, side_s3, side_s4;
	tail_t       tail_s5, tail_s6, tail_s7;
	mu_in_t      dil_in, ero_in;
	logic        dil_valid, dil_res, ero_valid, ero_res;
	logic        room, push;
	logic [7:0]  out_pix;
	logic [FIFO_CW-1:0] level;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kernel_q <= 4'd3;
			width_q  <= 11'd1024;
			height_q <= 16'd1024;
		end else if (cfg_valid) begin
			case (cfg_idx_t'(cfg_index))
				CFG_KERNEL: kernel_q <= cfg_data[3:0];
				CFG_WIDTH:  width_q  <= cfg_data[10:0];
				CFG_HEIGHT: height_q <= cfg_data;
				default:    kernel_q <= kernel_q;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx_t'(cfg_index))
			CFG_KERNEL, CFG_WIDTH, CFG_HEIGHT: cfg_clear = cfg_valid;
			default:                           cfg_clear = 1'b0;
		endcase
	end

	// clamped geometry
	always_comb begin
		keff = (kernel_q == 4'd0) ? 4'd1 : kernel_q;
		hi4  = keff - 4'd1 - (keff >> 1);
		cfg.k  = keff;
		cfg.hi = hi4[2:0];
		cfg.w  = (width_q == 11'd0) ? 11'd1 :
		         (width_q > 11'(MAX_WIDTH)) ? 11'(MAX_WIDTH) : width_q;
		cfg.h  = (height_q == 16'd0) ? 16'd1 : height_q;
		cfg.ld     = LD_W'(cfg.hi) * (LD_W'(cfg.w) + LD_W'(1));
		cfg.two_ld = {cfg.ld[LD_W-2:0], 1'b0};
	end

	ocmf_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.clear    (cfg_clear),
		.room     (room),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.ev_s1    (ev_s1),
		.pix_s1   (pix_s1)
	);

	// dilation of the obstacle mask, every position
	always_comb begin
		dil_in.valid  = ev_s1.valid;
		dil_in.bit_in = ev_s1.bit_in;
		dil_in.row    = ev_s1.in_row;
		dil_in.col    = ev_s1.in_col;
		dil_in.ccol   = ev_s1.dil_col;
	end

	ocmf_morph u_dilate (
		.clk       (clk),
		.arst_n    (arst_n),
		.erode     (1'b0),
		.cfg       (cfg),
		.mu_in     (dil_in),
		.res_valid (dil_valid),
		.res       (dil_res)
	);

	// side data alongside the dilate unit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s2 <= '0;
			side_s3 <= '0;
			side_s4 <= '0;
		end else begin
			side_s2.valid   <= ev_s1.valid;
			side_s2.dil_act <= ev_s1.dil_act;
			side_s2.dil_row <= ev_s1.dil_row;
			side_s2.dil_col <= ev_s1.dil_col;
			side_s2.out_col <= ev_s1.out_col;
			side_s2.emit    <= ev_s1.emit;
			side_s2.last    <= ev_s1.last;
			side_s2.pix     <= pix_s1;
			side_s3         <= side_s2;
			side_s4         <= side_s3;
		end
	end

	// erosion of the dilated mask, once the dilated stream has started
	always_comb begin
		ero_in.valid  = dil_valid && side_s4.dil_act;
		ero_in.bit_in = dil_res;
		ero_in.row    = side_s4.dil_row;
		ero_in.col    = side_s4.dil_col;
		ero_in.ccol   = side_s4.out_col;
	end

	ocmf_morph u_erode (
		.clk       (clk),
		.arst_n    (arst_n),
		.erode     (1'b1),
		.cfg       (cfg),
		.mu_in     (ero_in),
		.res_valid (ero_valid),
		.res       (ero_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tail_s5 <= '0;
			tail_s6 <= '0;
			tail_s7 <= '0;
		end else begin
			tail_s5.emit <= side_s4.valid && side_s4.emit;
			tail_s5.last <= side_s4.last;
			tail_s5.pix  <= side_s4.pix;
			tail_s6      <= tail_s5;
			tail_s7      <= tail_s6;
		end
	end

	// closed obstacle clears everything that is not free
	assign push    = ero_valid && tail_s7.emit;
	assign out_pix = (ero_res && (tail_s7.pix != PIX_FREE)) ? PIX_OBST : tail_s7.pix;

	ocmf_out_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_pix  (out_pix),
		.push_last (tail_s7.last),
		.room      (room),
		.level     (level),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

`ifndef NO_ASSERTIONS
	// the queue reserves room for every item in flight
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (level < FIFO_CW'(FIFO_DEPTH)))
		else $error("output queue overflow");

	// an output position implies the dilated stream is running
	a_emit_after_dilate: assert property (@(posedge clk) disable iff (!arst_n)
		(ev_s1.valid && ev_s1.emit) |-> ev_s1.dil_act)
		else $error("output issued before dilation start");

	// every emitting position in the side data lines up with a dilate result
	a_push_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		(side_s4.valid && side_s4.emit) |-> dil_valid)
		else $error("dilate unit out of step with side data");
`endif

endmodule
